/* rtl/dpw_pkg.sv */
// Shared types, widths and fixed-point constants of the depth-to-world back-projection block.
package dpw_pkg;

  // Configuration port
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Field widths
  localparam int HGT_W   = 13;
  localparam int RNG_W   = 14;
  localparam int IDX_W   = 4;
  localparam int COEF_W  = 32;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DEPTH_W = 13;
  localparam int OUT_W   = 21;

  // Internal arithmetic widths
  localparam int NX_W     = 13;
  localparam int CAM_W    = 27;
  localparam int CZ_W     = 25;
  localparam int FOC_W    = 12;
  localparam int PROD_W   = 58;
  localparam int PAIR_W   = 59;
  localparam int NUM_W    = 60;
  localparam int U_W      = 30;
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 32;
  localparam int Q_W      = 21;
  localparam int DIV_SH   = 17;

  // Matrix geometry
  localparam int MAT_N    = 12;
  localparam int ROW_N    = 3;
  localparam int MAT_COLS = 4;
  localparam logic [IDX_W-1:0] COEF_LAST = 4'd11;

  localparam logic signed [FOC_W-1:0]  FOCAL_TWICE = 12'sd1190;
  localparam logic [9:0]               FOCAL       = 10'd595;
  localparam logic signed [COEF_W-1:0] Q_ONE       = 32'sd65536;

  // Rounding divides by 1190 * 65536: shift by 17, then multiply by the reciprocal of 595.
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(64'd4294967296 / 64'd595);
  localparam logic [NUM_W-1:0]   HALF_DEN = NUM_W'(64'd38993920);
  localparam logic [NUM_W-1:0]   POS_LIM  = NUM_W'(64'd1048576 * 64'd77987840 - 64'd38993920);
  localparam logic [NUM_W-1:0]   NEG_LIM  = NUM_W'(64'd1048577 * 64'd77987840 - 64'd38993920);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_HEIGHT_UPPER  = 3'd0,
    REG_HEIGHT_LOWER  = 3'd1,
    REG_CAMERA_HEIGHT = 3'd2,
    REG_RANGE_FAR     = 3'd3,
    REG_RANGE_NEAR    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] height_upper;
    logic signed [HGT_W-1:0] height_lower;
    logic signed [HGT_W-1:0] camera_height;
    logic [RNG_W-1:0]        range_far;
    logic [RNG_W-1:0]        range_near;
  } cfg_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [COL_W-1:0]         pixel_column;
    logic [ROW_W-1:0]         pixel_row;
    logic [DEPTH_W-1:0]       depth_mm;
  } pix_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [CAM_W-1:0]  cam_x;
    logic signed [CAM_W-1:0]  cam_y;
    logic signed [CZ_W-1:0]   cam_z;
  } cam_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [NUM_W-1:0] num_z;
  } num_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic signed [OUT_W-1:0] world_z;
  } pnt_t;

endpackage

/* rtl/dpw_if.sv */
// Request and result channel interfaces of the depth-to-world block.
interface dpw_in_if;
  import dpw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic [COL_W-1:0]         pixel_column;
  logic [ROW_W-1:0]         pixel_row;
  logic [DEPTH_W-1:0]       depth_mm;

  modport source (output valid, output opcode, output coef_index, output coef_value,
                  output pixel_column, output pixel_row, output depth_mm, input ready);
  modport sink (input valid, input opcode, input coef_index, input coef_value,
                input pixel_column, input pixel_row, input depth_mm, output ready);
endinterface

interface dpw_out_if;
  import dpw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] world_x;
  logic signed [OUT_W-1:0] world_y;
  logic signed [OUT_W-1:0] world_z;

  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

/* rtl/dpw_cfg_regs.sv */
// APB-style configuration registers for the height and depth bands.
module dpw_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpw_pkg::ADDR_W-1:0] paddr,
  input  logic [dpw_pkg::DATA_W-1:0] pwdata,
  output logic [dpw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dpw_pkg::cfg_t              cfg
);
  import dpw_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.height_upper  <= {1'b0, {(HGT_W-1){1'b1}}};
      cfg_r.height_lower  <= {1'b1, {(HGT_W-1){1'b0}}};
      cfg_r.camera_height <= '0;
      cfg_r.range_far     <= '1;
      cfg_r.range_near    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_HEIGHT_UPPER:  cfg_r.height_upper  <= pwdata[HGT_W-1:0];
        REG_HEIGHT_LOWER:  cfg_r.height_lower  <= pwdata[HGT_W-1:0];
        REG_CAMERA_HEIGHT: cfg_r.camera_height <= pwdata[HGT_W-1:0];
        REG_RANGE_FAR:     cfg_r.range_far     <= pwdata[RNG_W-1:0];
        REG_RANGE_NEAR:    cfg_r.range_near    <= pwdata[RNG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEIGHT_UPPER:  prdata = DATA_W'($signed(cfg_r.height_upper));
      REG_HEIGHT_LOWER:  prdata = DATA_W'($signed(cfg_r.height_lower));
      REG_CAMERA_HEIGHT: prdata = DATA_W'($signed(cfg_r.camera_height));
      REG_RANGE_FAR:     prdata = DATA_W'(cfg_r.range_far);
      REG_RANGE_NEAR:    prdata = DATA_W'(cfg_r.range_near);
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/dpw_camera.sv */
// Back-projection stages: pixel offsets and depth band, then scaled camera coordinates.
module dpw_camera #(
  parameter int IMAGE_COLUMNS = 640,
  parameter int IMAGE_ROWS    = 480
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dpw_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpw_pkg::pix_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output dpw_pkg::cam_t out_item
);
  import dpw_pkg::*;

  localparam logic signed [NX_W-1:0] COL_OFF = NX_W'(IMAGE_COLUMNS - 1);
  localparam logic signed [NX_W-1:0] ROW_OFF = NX_W'(IMAGE_ROWS - 1);

  logic                     a_v_r;
  logic                     a_v_nxt;
  logic                     a_en;
  opcode_t                  a_op_r;
  logic [IDX_W-1:0]         a_idx_r;
  logic signed [COEF_W-1:0] a_coef_r;
  logic signed [NX_W-1:0]   a_nx_r;
  logic signed [NX_W-1:0]   a_ny_r;
  logic signed [NX_W-1:0]   a_nx_nxt;
  logic signed [NX_W-1:0]   a_ny_nxt;
  logic [DEPTH_W-1:0]       a_d_r;
  logic                     depth_ok;

  logic                     b_v_r;
  logic                     b_en;
  cam_t                     b_item_r;
  cam_t                     b_item_nxt;
  logic signed [CAM_W-1:0]  d_ext;
  logic signed [CAM_W-1:0]  z_full;

  assign b_en     = !b_v_r || out_ready;
  assign a_en     = !a_v_r || b_en;
  assign in_ready = a_en;

  // Pixels outside the depth band leave here; loads always go on.
  assign depth_ok = (RNG_W'(in_item.depth_mm) <= cfg.range_far) &&
                    (RNG_W'(in_item.depth_mm) >= cfg.range_near);
  assign a_v_nxt  = in_valid && ((in_item.opcode == OP_LOAD) || depth_ok);
  assign a_nx_nxt = $signed({2'b00, in_item.pixel_column, 1'b0}) - COL_OFF;
  assign a_ny_nxt = $signed({3'b000, in_item.pixel_row, 1'b0}) - ROW_OFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_en) begin
      a_v_r <= a_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_op_r   <= in_item.opcode;
      a_idx_r  <= in_item.coef_index;
      a_coef_r <= in_item.coef_value;
      a_nx_r   <= a_nx_nxt;
      a_ny_r   <= a_ny_nxt;
      a_d_r    <= in_item.depth_mm;
    end
  end

  // Camera coordinates carry a factor of 1190 so that they stay integral.
  always_comb begin
    d_ext                 = $signed({{(CAM_W-DEPTH_W){1'b0}}, a_d_r});
    z_full                = -(d_ext * CAM_W'(FOCAL_TWICE));
    b_item_nxt.opcode     = a_op_r;
    b_item_nxt.coef_index = a_idx_r;
    b_item_nxt.coef_value = a_coef_r;
    b_item_nxt.cam_x      = CAM_W'(a_nx_r) * d_ext;
    b_item_nxt.cam_y      = CAM_W'($signed(cfg.camera_height)) * CAM_W'(FOCAL_TWICE) -
                            CAM_W'(a_ny_r) * d_ext;
    b_item_nxt.cam_z      = z_full[CZ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_v_r;
  assign out_item  = b_item_r;

endmodule

/* rtl/dpw_transform.sv */
// Camera-to-world matrix store, height band and the three-stage multiply-accumulate.
module dpw_transform (
  input  logic          clk,
  input  logic          rst_n,
  input  dpw_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpw_pkg::cam_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output dpw_pkg::num_t out_item
);
  import dpw_pkg::*;

  logic signed [COEF_W-1:0] mat_r [MAT_N];

  logic                     p_v_r;
  logic                     p_v_nxt;
  logic                     p_en;
  logic signed [PROD_W-1:0] p_r [MAT_N];
  logic signed [PROD_W-1:0] p_nxt [MAT_N];
  logic signed [CAM_W-1:0]  hu_scaled;
  logic signed [CAM_W-1:0]  hl_scaled;
  logic                     height_ok;
  logic                     load_en;

  logic                     s_v_r;
  logic                     s_en;
  logic signed [PAIR_W-1:0] s_r [2*ROW_N];

  logic                     n_v_r;
  logic                     n_en;
  logic signed [NUM_W-1:0]  n_r [ROW_N];

  assign n_en     = !n_v_r || out_ready;
  assign s_en     = !s_v_r || n_en;
  assign p_en     = !p_v_r || s_en;
  assign in_ready = p_en;

  // A load updates the matrix as it passes the product stage, so items keep their order.
  assign load_en = in_valid && p_en && (in_item.opcode == OP_LOAD) &&
                   (in_item.coef_index <= COEF_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROW_N; r++) begin
        for (int c = 0; c < MAT_COLS; c++) begin
          mat_r[r*MAT_COLS+c] <= (r == c) ? Q_ONE : '0;
        end
      end
    end else if (load_en) begin
      mat_r[in_item.coef_index] <= in_item.coef_value;
    end
  end

  assign hu_scaled = CAM_W'($signed(cfg.height_upper)) * CAM_W'(FOCAL_TWICE);
  assign hl_scaled = CAM_W'($signed(cfg.height_lower)) * CAM_W'(FOCAL_TWICE);
  assign height_ok = !(in_item.cam_y > hu_scaled) && !(in_item.cam_y < hl_scaled);
  assign p_v_nxt   = in_valid && (in_item.opcode == OP_PIXEL) && height_ok;

  always_comb begin
    for (int r = 0; r < ROW_N; r++) begin
      p_nxt[r*MAT_COLS]   = PROD_W'(mat_r[r*MAT_COLS]) * PROD_W'(in_item.cam_x);
      p_nxt[r*MAT_COLS+1] = PROD_W'(mat_r[r*MAT_COLS+1]) * PROD_W'(in_item.cam_y);
      p_nxt[r*MAT_COLS+2] = PROD_W'(mat_r[r*MAT_COLS+2]) * PROD_W'(in_item.cam_z);
      p_nxt[r*MAT_COLS+3] = PROD_W'(mat_r[r*MAT_COLS+3]) * PROD_W'(FOCAL_TWICE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      n_v_r <= 1'b0;
    end else begin
      if (p_en) begin
        p_v_r <= p_v_nxt;
      end
      if (s_en) begin
        s_v_r <= p_v_r;
      end
      if (n_en) begin
        n_v_r <= s_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      p_r <= p_nxt;
    end
    if (s_en) begin
      for (int r = 0; r < ROW_N; r++) begin
        s_r[2*r]   <= PAIR_W'(p_r[r*MAT_COLS])   + PAIR_W'(p_r[r*MAT_COLS+1]);
        s_r[2*r+1] <= PAIR_W'(p_r[r*MAT_COLS+2]) + PAIR_W'(p_r[r*MAT_COLS+3]);
      end
    end
    if (n_en) begin
      for (int r = 0; r < ROW_N; r++) begin
        n_r[r] <= NUM_W'(s_r[2*r]) + NUM_W'(s_r[2*r+1]);
      end
    end
  end

  assign out_valid      = n_v_r;
  assign out_item.num_x = n_r[0];
  assign out_item.num_y = n_r[1];
  assign out_item.num_z = n_r[2];

endmodule

/* rtl/dpw_round.sv */
// Rounding to whole millimetres with saturation, one lane per world axis.
module dpw_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpw_pkg::num_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output dpw_pkg::pnt_t out_item
);
  import dpw_pkg::*;

  localparam int HP_W = U_W + RECIP_W;

  logic signed [NUM_W-1:0] num_in [ROW_N];

  logic                   f_v_r, f_en;
  logic                   f_neg_r [ROW_N];
  logic [NUM_W-1:0]       f_mag_r [ROW_N];

  logic                   g_v_r, g_en;
  logic                   g_neg_r [ROW_N];
  logic                   g_sat_r [ROW_N];
  logic [U_W-1:0]         g_u_r [ROW_N];
  logic [NUM_W-1:0]       g_sum [ROW_N];

  logic                   h_v_r, h_en;
  logic                   h_neg_r [ROW_N];
  logic                   h_sat_r [ROW_N];
  logic [U_W-1:0]         h_u_r [ROW_N];
  logic [Q_W-1:0]         h_q0_r [ROW_N];
  logic [HP_W-1:0]        h_prod [ROW_N];

  logic                   i_v_r, i_en;
  logic                   i_neg_r [ROW_N];
  logic                   i_sat_r [ROW_N];
  logic [Q_W-1:0]         i_q0_r [ROW_N];
  logic                   i_inc_r [ROW_N];
  logic [U_W-1:0]         i_rem [ROW_N];

  logic                   o_v_r, o_en;
  logic signed [OUT_W-1:0] o_val_r [ROW_N];
  logic signed [OUT_W-1:0] o_val_nxt [ROW_N];
  logic [Q_W-1:0]         o_q [ROW_N];

  assign num_in[0] = in_item.num_x;
  assign num_in[1] = in_item.num_y;
  assign num_in[2] = in_item.num_z;

  assign o_en     = !o_v_r || out_ready;
  assign i_en     = !i_v_r || o_en;
  assign h_en     = !h_v_r || i_en;
  assign g_en     = !g_v_r || h_en;
  assign f_en     = !f_v_r || g_en;
  assign in_ready = f_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (f_en) begin
        f_v_r <= in_valid;
      end
      if (g_en) begin
        g_v_r <= f_v_r;
      end
      if (h_en) begin
        h_v_r <= g_v_r;
      end
      if (i_en) begin
        i_v_r <= h_v_r;
      end
      if (o_en) begin
        o_v_r <= i_v_r;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < ROW_N; l++) begin
      g_sum[l]  = f_mag_r[l] + HALF_DEN;
      h_prod[l] = HP_W'(g_u_r[l]) * HP_W'(RECIP);
      i_rem[l]  = h_u_r[l] - U_W'(h_q0_r[l]) * U_W'(FOCAL);
      o_q[l]    = i_q0_r[l] + Q_W'(i_inc_r[l]);
      if (i_sat_r[l]) begin
        o_val_nxt[l] = i_neg_r[l] ? OUT_MIN : OUT_MAX;
      end else if (i_neg_r[l]) begin
        o_val_nxt[l] = $signed(Q_W'(0) - o_q[l]);
      end else begin
        o_val_nxt[l] = $signed(o_q[l]);
      end
    end
  end

  // Saturation is settled on the magnitude first, so the quotient path only sees small values.
  // The reciprocal estimate is at most one short; the remainder check adds it back.
  always_ff @(posedge clk) begin
    for (int l = 0; l < ROW_N; l++) begin
      if (f_en) begin
        f_neg_r[l] <= num_in[l][NUM_W-1];
        f_mag_r[l] <= num_in[l][NUM_W-1] ? NUM_W'(-num_in[l]) : NUM_W'(num_in[l]);
      end
      if (g_en) begin
        g_neg_r[l] <= f_neg_r[l];
        g_sat_r[l] <= f_neg_r[l] ? (f_mag_r[l] >= NEG_LIM) : (f_mag_r[l] >= POS_LIM);
        g_u_r[l]   <= g_sum[l][DIV_SH+U_W-1:DIV_SH];
      end
      if (h_en) begin
        h_neg_r[l] <= g_neg_r[l];
        h_sat_r[l] <= g_sat_r[l];
        h_u_r[l]   <= g_u_r[l];
        h_q0_r[l]  <= h_prod[l][RECIP_SH+Q_W-1:RECIP_SH];
      end
      if (i_en) begin
        i_neg_r[l] <= h_neg_r[l];
        i_sat_r[l] <= h_sat_r[l];
        i_q0_r[l]  <= h_q0_r[l];
        i_inc_r[l] <= i_rem[l] >= U_W'(FOCAL);
      end
      if (o_en) begin
        o_val_r[l] <= o_val_nxt[l];
      end
    end
  end

  assign out_valid        = o_v_r;
  assign out_item.world_x = o_val_r[0];
  assign out_item.world_y = o_val_r[1];
  assign out_item.world_z = o_val_r[2];

endmodule

/* rtl/depth_pixel_to_world_point.sv */
// Top level: back-projects depth pixels and maps kept points into the world frame.
// Pipeline: ten register stages (camera a, b; transform p, s, n; rounding f, g, h, i, o).
// Throughput: one request per cycle while out_ch.ready holds; coefficient loads and dropped pixels give no result.
// Each stage has its own valid bit and moves whenever the stage after it is empty or moving.
// Reset (rst_n low, synchronous) empties the pipeline, restores the register defaults
// and loads an identity rotation with zero translation into the matrix.
module depth_pixel_to_world_point #(
  parameter int IMAGE_COLUMNS = 640,
  parameter int IMAGE_ROWS    = 480
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dpw_in_if.sink                     in_ch,
  dpw_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpw_pkg::ADDR_W-1:0] paddr,
  input  logic [dpw_pkg::DATA_W-1:0] pwdata,
  output logic [dpw_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import dpw_pkg::*;

  cfg_t cfg;
  pix_t pix;
  cam_t cam_item;
  num_t num_item;
  pnt_t pnt_item;
  logic cam_valid, cam_ready;
  logic num_valid, num_ready;

  assign pix.opcode       = opcode_t'(in_ch.opcode);
  assign pix.coef_index   = in_ch.coef_index;
  assign pix.coef_value   = in_ch.coef_value;
  assign pix.pixel_column = in_ch.pixel_column;
  assign pix.pixel_row    = in_ch.pixel_row;
  assign pix.depth_mm     = in_ch.depth_mm;

  dpw_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpw_camera #(
    .IMAGE_COLUMNS (IMAGE_COLUMNS),
    .IMAGE_ROWS    (IMAGE_ROWS)
  ) u_camera (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (pix),
    .out_valid (cam_valid),
    .out_ready (cam_ready),
    .out_item  (cam_item)
  );

  dpw_transform u_transform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (cam_valid),
    .in_ready  (cam_ready),
    .in_item   (cam_item),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_item  (num_item)
  );

  dpw_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_item   (num_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (pnt_item)
  );

  assign out_ch.world_x = pnt_item.world_x;
  assign out_ch.world_y = pnt_item.world_y;
  assign out_ch.world_z = pnt_item.world_z;

endmodule

/* rtl/dpw_checker.sv */
// Port-level checks for the depth-to-world block and their binding to the top level.
module dpw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dpw_pkg::OUT_W-1:0]  world_x,
  input logic [dpw_pkg::OUT_W-1:0]  world_y,
  input logic [dpw_pkg::OUT_W-1:0]  world_z,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [dpw_pkg::ADDR_W-1:0] paddr,
  input logic [dpw_pkg::DATA_W-1:0] pwdata,
  input logic [dpw_pkg::DATA_W-1:0] prdata
);
  import dpw_pkg::*;

  logic wr_far;
  logic rd_far;

  assign wr_far = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_RANGE_FAR);
  assign rd_far = paddr[ADDR_W-1:2] == REG_RANGE_FAR;

  // A result that waits must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(world_x) && $stable(world_y) &&
                                  $stable(world_z))
    else $error("result changed while stalled");

  // A refused request stays on offer until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before it was taken");

  // With the result side taking everything, no stage can be blocked.
  a_no_stall: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("request refused while results drain");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("result shown straight after reset");

  // A written far range reads back the written bits.
  a_far_readback: assert property (@(posedge clk) disable iff (!rst_n)
      wr_far |=> (!rd_far || (prdata == DATA_W'($past(pwdata[RNG_W-1:0])))))
    else $error("far range readback mismatch");

endmodule

bind depth_pixel_to_world_point dpw_checker u_dpw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .world_x   (out_ch.world_x),
  .world_y   (out_ch.world_y),
  .world_z   (out_ch.world_z),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
